@@ hdl/tun_pkg.sv @@
package tun_pkg;

  localparam int COORD_W  = 16;
  localparam int EDGE_W   = COORD_W + 1;
  localparam int PROD_W   = 2 * EDGE_W;
  localparam int MAG_W    = PROD_W;
  localparam int HALF_W   = MAG_W / 2;
  localparam int SUM_W    = 2 * MAG_W;
  localparam int ROOT_W   = SUM_W / 2;
  localparam int SQ_REM_W = ROOT_W + 2;
  localparam int DIV_REM_W = MAG_W + 2;
  localparam int FRAC     = 15;
  localparam int NORM_W   = FRAC + 1;
  localparam int DIV_STEPS = FRAC + 1;

  typedef logic [MAG_W-1:0]     mag_t;
  typedef logic [ROOT_W-1:0]    root_t;
  typedef logic [DIV_REM_W-1:0] drem_t;
  typedef logic [NORM_W-1:0]    quot_t;

  typedef struct packed {
    mag_t       x;
    mag_t       y;
    mag_t       z;
    logic [2:0] neg;
    logic       nz;
  } tun_cross_t;

  typedef struct packed {
    root_t      len;
    drem_t      rx;
    drem_t      ry;
    drem_t      rz;
    quot_t      qx;
    quot_t      qy;
    quot_t      qz;
    logic [2:0] neg;
    logic       nz;
  } tun_div_t;

endpackage

@@ hdl/tun_sqrt_cell.sv @@
module tun_sqrt_cell (
  input  logic                                    clk,
  input  logic                                    rst_n,
  input  logic                                    en,
  input  logic                                    valid_in,
  input  logic [tun_pkg::SUM_W-1:0]               rad_in,
  input  logic [tun_pkg::ROOT_W-1:0]              root_in,
  input  logic [tun_pkg::SQ_REM_W-1:0]            rem_in,
  input  tun_pkg::tun_cross_t                     vec_in,
  output logic                                    valid_out,
  output logic [tun_pkg::SUM_W-1:0]               rad_out,
  output logic [tun_pkg::ROOT_W-1:0]              root_out,
  output logic [tun_pkg::SQ_REM_W-1:0]            rem_out,
  output tun_pkg::tun_cross_t                     vec_out
);
  import tun_pkg::*;

  logic [SQ_REM_W+1:0] cur;
  logic [SQ_REM_W+1:0] trial;
  logic                ge;

  logic                valid_r;
  logic [SUM_W-1:0]    rad_r;
  logic [ROOT_W-1:0]   root_r;
  logic [SQ_REM_W-1:0] rem_r;
  tun_cross_t          vec_r;

  always_comb begin
    cur   = {rem_in, rad_in[SUM_W-1 -: 2]};
    trial = (SQ_REM_W+2)'({root_in, 2'b01});
    ge    = (cur >= trial);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= valid_in;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rad_r  <= {rad_in[SUM_W-3:0], 2'b00};
      root_r <= {root_in[ROOT_W-2:0], ge};
      rem_r  <= ge ? SQ_REM_W'(cur - trial) : SQ_REM_W'(cur);
      vec_r  <= vec_in;
    end
  end

  assign valid_out = valid_r;
  assign rad_out   = rad_r;
  assign root_out  = root_r;
  assign rem_out   = rem_r;
  assign vec_out   = vec_r;

endmodule

@@ hdl/tun_div_cell.sv @@
module tun_div_cell (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              en,
  input  logic              valid_in,
  input  tun_pkg::tun_div_t st_in,
  output logic              valid_out,
  output tun_pkg::tun_div_t st_out
);
  import tun_pkg::*;

  drem_t    dv;
  logic     gx, gy, gz;
  tun_div_t st_nxt;
  tun_div_t st_r;
  logic     valid_r;

  always_comb begin
    dv     = DIV_REM_W'(st_in.len);
    gx     = (st_in.rx >= dv);
    gy     = (st_in.ry >= dv);
    gz     = (st_in.rz >= dv);
    st_nxt = st_in;
    // compare and subtract, then shift in the next numerator bit (always zero)
    st_nxt.rx = (gx ? (st_in.rx - dv) : st_in.rx) << 1;
    st_nxt.ry = (gy ? (st_in.ry - dv) : st_in.ry) << 1;
    st_nxt.rz = (gz ? (st_in.rz - dv) : st_in.rz) << 1;
    st_nxt.qx = {st_in.qx[NORM_W-2:0], gx};
    st_nxt.qy = {st_in.qy[NORM_W-2:0], gy};
    st_nxt.qz = {st_in.qz[NORM_W-2:0], gz};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= valid_in;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      st_r <= st_nxt;
    end
  end

  assign valid_out = valid_r;
  assign st_out    = st_r;

endmodule

@@ hdl/triangle_unit_normal_unit.sv @@
// unit face normal of one triangle per transaction
// input channel: in_valid/in_ready carry vertices a, b, c as signed q8.8 coordinates
// output channel: out_valid/out_ready carry the q1.15 normal and nonzero_area
// the whole datapath is one pipeline of 57 register stages: edges, products,
// cross product, two squaring stages, sum of squares, 34 square-root cells
// (one root bit each) and 16 divider cells (one quotient bit each, three lanes),
// then the output register
// throughput: one transaction per cycle while the receiver keeps out_ready high
// the pipeline moves only when the output register is empty or being taken, so
// a stalled receiver freezes every stage and in_ready falls in the same cycle
// in_ready depends combinationally on out_valid and out_ready
// reset (rst_n low, synchronous) clears all stage valid bits; no data is lost
// other than transactions in flight
// a zero cross product gives a zero normal with nonzero_area low
module triangle_unit_normal_unit (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic signed [tun_pkg::COORD_W-1:0]  in_vertex_a_x,
  input  logic signed [tun_pkg::COORD_W-1:0]  in_vertex_a_y,
  input  logic signed [tun_pkg::COORD_W-1:0]  in_vertex_a_z,
  input  logic signed [tun_pkg::COORD_W-1:0]  in_vertex_b_x,
  input  logic signed [tun_pkg::COORD_W-1:0]  in_vertex_b_y,
  input  logic signed [tun_pkg::COORD_W-1:0]  in_vertex_b_z,
  input  logic signed [tun_pkg::COORD_W-1:0]  in_vertex_c_x,
  input  logic signed [tun_pkg::COORD_W-1:0]  in_vertex_c_y,
  input  logic signed [tun_pkg::COORD_W-1:0]  in_vertex_c_z,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [tun_pkg::NORM_W-1:0]   out_normal_x,
  output logic signed [tun_pkg::NORM_W-1:0]   out_normal_y,
  output logic signed [tun_pkg::NORM_W-1:0]   out_normal_z,
  output logic                                out_nonzero_area
);
  import tun_pkg::*;

  logic en;
  logic v1_r, v2_r, v3_r, v4_r, v5_r, v6_r;
  logic out_valid_r;

  // stage 1: edges
  logic signed [EDGE_W-1:0] e1x_r, e1y_r, e1z_r, e2x_r, e2y_r, e2z_r;
  // stage 2: signed products
  logic signed [PROD_W-1:0] pxa_r, pxb_r, pya_r, pyb_r, pza_r, pzb_r;
  // stage 3: cross product magnitude and sign
  tun_cross_t cr3_r;
  // stage 4: partial squares
  logic [MAG_W-1:0] hhx_r, hlx_r, llx_r, hhy_r, hly_r, lly_r, hhz_r, hlz_r, llz_r;
  tun_cross_t cr4_r;
  // stage 5: per-component squares
  logic [SUM_W-1:0] sqx_r, sqy_r, sqz_r;
  tun_cross_t cr5_r;
  // stage 6: sum of squares
  logic [SUM_W-1:0] sum_r;
  tun_cross_t cr6_r;

  logic signed [PROD_W:0] cx, cy, cz;
  logic [SUM_W-1:0]       sum_nxt;

  logic normal_nz_r;
  logic signed [NORM_W-1:0] nx_r, ny_r, nz_r;

  assign en       = !out_valid_r || out_ready;
  assign in_ready = en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      v5_r <= 1'b0;
      v6_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
      v5_r <= v4_r;
      v6_r <= v5_r;
    end
  end

  always_comb begin
    cx = $signed({pxa_r[PROD_W-1], pxa_r}) - $signed({pxb_r[PROD_W-1], pxb_r});
    cy = $signed({pya_r[PROD_W-1], pya_r}) - $signed({pyb_r[PROD_W-1], pyb_r});
    cz = $signed({pza_r[PROD_W-1], pza_r}) - $signed({pzb_r[PROD_W-1], pzb_r});
    sum_nxt = sqx_r + sqy_r + sqz_r;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      e1x_r <= EDGE_W'(in_vertex_b_x) - EDGE_W'(in_vertex_a_x);
      e1y_r <= EDGE_W'(in_vertex_b_y) - EDGE_W'(in_vertex_a_y);
      e1z_r <= EDGE_W'(in_vertex_b_z) - EDGE_W'(in_vertex_a_z);
      e2x_r <= EDGE_W'(in_vertex_c_x) - EDGE_W'(in_vertex_a_x);
      e2y_r <= EDGE_W'(in_vertex_c_y) - EDGE_W'(in_vertex_a_y);
      e2z_r <= EDGE_W'(in_vertex_c_z) - EDGE_W'(in_vertex_a_z);

      pxa_r <= e1y_r * e2z_r;
      pxb_r <= e1z_r * e2y_r;
      pya_r <= e1z_r * e2x_r;
      pyb_r <= e1x_r * e2z_r;
      pza_r <= e1x_r * e2y_r;
      pzb_r <= e1y_r * e2x_r;

      cr3_r.x   <= cx[PROD_W] ? MAG_W'(-cx) : MAG_W'(cx);
      cr3_r.y   <= cy[PROD_W] ? MAG_W'(-cy) : MAG_W'(cy);
      cr3_r.z   <= cz[PROD_W] ? MAG_W'(-cz) : MAG_W'(cz);
      cr3_r.neg <= {cz[PROD_W], cy[PROD_W], cx[PROD_W]};
      cr3_r.nz  <= 1'b0;

      // split each magnitude in halves to keep multipliers narrow
      hhx_r <= cr3_r.x[MAG_W-1:HALF_W] * cr3_r.x[MAG_W-1:HALF_W];
      hlx_r <= cr3_r.x[MAG_W-1:HALF_W] * cr3_r.x[HALF_W-1:0];
      llx_r <= cr3_r.x[HALF_W-1:0] * cr3_r.x[HALF_W-1:0];
      hhy_r <= cr3_r.y[MAG_W-1:HALF_W] * cr3_r.y[MAG_W-1:HALF_W];
      hly_r <= cr3_r.y[MAG_W-1:HALF_W] * cr3_r.y[HALF_W-1:0];
      lly_r <= cr3_r.y[HALF_W-1:0] * cr3_r.y[HALF_W-1:0];
      hhz_r <= cr3_r.z[MAG_W-1:HALF_W] * cr3_r.z[MAG_W-1:HALF_W];
      hlz_r <= cr3_r.z[MAG_W-1:HALF_W] * cr3_r.z[HALF_W-1:0];
      llz_r <= cr3_r.z[HALF_W-1:0] * cr3_r.z[HALF_W-1:0];
      cr4_r <= cr3_r;

      sqx_r <= (SUM_W'(hhx_r) << (2*HALF_W)) + (SUM_W'(hlx_r) << (HALF_W+1)) + SUM_W'(llx_r);
      sqy_r <= (SUM_W'(hhy_r) << (2*HALF_W)) + (SUM_W'(hly_r) << (HALF_W+1)) + SUM_W'(lly_r);
      sqz_r <= (SUM_W'(hhz_r) << (2*HALF_W)) + (SUM_W'(hlz_r) << (HALF_W+1)) + SUM_W'(llz_r);
      cr5_r <= cr4_r;

      sum_r     <= sum_nxt;
      cr6_r.x   <= cr5_r.x;
      cr6_r.y   <= cr5_r.y;
      cr6_r.z   <= cr5_r.z;
      cr6_r.neg <= cr5_r.neg;
      cr6_r.nz  <= (sum_nxt != '0);
    end
  end

  // square root chain
  logic                sq_v   [0:ROOT_W];
  logic [SUM_W-1:0]    sq_rad [0:ROOT_W];
  logic [ROOT_W-1:0]   sq_root[0:ROOT_W];
  logic [SQ_REM_W-1:0] sq_rem [0:ROOT_W];
  tun_cross_t          sq_vec [0:ROOT_W];

  assign sq_v[0]    = v6_r;
  assign sq_rad[0]  = sum_r;
  assign sq_root[0] = '0;
  assign sq_rem[0]  = '0;
  assign sq_vec[0]  = cr6_r;

  for (genvar i = 0; i < ROOT_W; i++) begin : g_sqrt
    tun_sqrt_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .en       (en),
      .valid_in (sq_v[i]),
      .rad_in   (sq_rad[i]),
      .root_in  (sq_root[i]),
      .rem_in   (sq_rem[i]),
      .vec_in   (sq_vec[i]),
      .valid_out(sq_v[i+1]),
      .rad_out  (sq_rad[i+1]),
      .root_out (sq_root[i+1]),
      .rem_out  (sq_rem[i+1]),
      .vec_out  (sq_vec[i+1])
    );
  end

  // divider chain
  logic     dv_v [0:DIV_STEPS];
  tun_div_t dv_st[0:DIV_STEPS];

  always_comb begin
    dv_st[0].len = sq_root[ROOT_W];
    dv_st[0].rx  = DIV_REM_W'(sq_vec[ROOT_W].x);
    dv_st[0].ry  = DIV_REM_W'(sq_vec[ROOT_W].y);
    dv_st[0].rz  = DIV_REM_W'(sq_vec[ROOT_W].z);
    dv_st[0].qx  = '0;
    dv_st[0].qy  = '0;
    dv_st[0].qz  = '0;
    dv_st[0].neg = sq_vec[ROOT_W].neg;
    dv_st[0].nz  = sq_vec[ROOT_W].nz;
  end
  assign dv_v[0] = sq_v[ROOT_W];

  for (genvar j = 0; j < DIV_STEPS; j++) begin : g_div
    tun_div_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .en       (en),
      .valid_in (dv_v[j]),
      .st_in    (dv_st[j]),
      .valid_out(dv_v[j+1]),
      .st_out   (dv_st[j+1])
    );
  end

  function automatic logic [NORM_W-1:0] fix_q(input logic [NORM_W-1:0] q, input logic neg,
                                               input logic nz);
    logic [NORM_W-1:0] v;
    v = '0;
    if (!nz) begin
      v = '0;
    end else if (neg) begin
      v = ~q + 1'b1;
    end else if (q[NORM_W-1]) begin
      // +1.0 saturates
      v = {1'b0, {(NORM_W-1){1'b1}}};
    end else begin
      v = q;
    end
    return v;
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= dv_v[DIV_STEPS];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      nx_r        <= fix_q(dv_st[DIV_STEPS].qx, dv_st[DIV_STEPS].neg[0], dv_st[DIV_STEPS].nz);
      ny_r        <= fix_q(dv_st[DIV_STEPS].qy, dv_st[DIV_STEPS].neg[1], dv_st[DIV_STEPS].nz);
      nz_r        <= fix_q(dv_st[DIV_STEPS].qz, dv_st[DIV_STEPS].neg[2], dv_st[DIV_STEPS].nz);
      normal_nz_r <= dv_st[DIV_STEPS].nz;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_normal_x     = nx_r;
  assign out_normal_y     = ny_r;
  assign out_normal_z     = nz_r;
  assign out_nonzero_area = normal_nz_r;

endmodule

@@ hdl/tun_checker.sv @@
module tun_checker (
  input logic                                clk,
  input logic                                rst_n,
  input logic                                in_ready,
  input logic                                out_valid,
  input logic                                out_ready,
  input logic signed [tun_pkg::NORM_W-1:0]   out_normal_x,
  input logic signed [tun_pkg::NORM_W-1:0]   out_normal_y,
  input logic signed [tun_pkg::NORM_W-1:0]   out_normal_z,
  input logic                                out_nonzero_area
);
  import tun_pkg::*;

  // stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_normal_x) &&
      $stable(out_normal_y) && $stable(out_normal_z) && $stable(out_nonzero_area))
    else $error("stalled result changed");

  // degenerate triangle gives a zero normal
  a_degen: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_nonzero_area |-> out_normal_x == '0 && out_normal_y == '0 &&
      out_normal_z == '0)
    else $error("degenerate triangle with nonzero normal");

  // pipeline advances whenever the output slot is free
  a_ready: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready == (!out_valid || out_ready))
    else $error("in_ready does not follow output slot");

  // nothing left over after reset
  a_reset: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("out_valid after reset");

  // a unit normal of a real triangle is never all zero
  a_unit: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_nonzero_area |-> out_normal_x != '0 || out_normal_y != '0 ||
      out_normal_z != '0)
    else $error("zero normal on nonzero area");

endmodule

bind triangle_unit_normal_unit tun_checker u_tun_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_ready        (in_ready),
  .out_valid       (out_valid),
  .out_ready       (out_ready),
  .out_normal_x    (out_normal_x),
  .out_normal_y    (out_normal_y),
  .out_normal_z    (out_normal_z),
  .out_nonzero_area(out_nonzero_area)
);
